FILE: rtl/core/ttw_pkg.sv
package ttw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 4);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int CELL_W = 16;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_CLEAR = 3'd1;
  localparam logic [2:0] CMD_SET   = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] RESET_COLOR = 8'h0F;

  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] glyph;
    logic [7:0] attribute;
    logic [7:0] target_col;
    logic [7:0] target_row;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic [10:0] cursor_index;
    logic [7:0]  read_glyph;
    logic [7:0]  read_attribute;
    logic        off_screen;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_FILL   = 4'b1000
  } state_t;

  function automatic logic [15:0] cell_addr(logic [7:0] row, logic [7:0] col);
    return 16'(row) * 16'(COLUMNS) + 16'(col);
  endfunction

endpackage

FILE: rtl/core/ttw_ram.sv
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/text_terminal_writer.sv
// channel  | handshake                      | payload
// ---------+--------------------------------+--------------------------
// input    | start, busy (word taken when   | in_data  (in_word_t)
//          | start & !busy)                 |
// result   | out_valid, one cycle per word  | out_data (out_word_t)
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// Put character, set cursor and write at position are done in idle; read cell goes
// through a read state for the registered memory read. Clear writes every cell, one
// memory write a cycle; a put character that scrolls then copies the rows up and
// blanks the last row through the single write port. After reset a clearing pass of
// CELLS cells (2000) fills the screen while busy stays high. The receiver cannot stall.
module text_terminal_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ttw_pkg::in_word_t   in_data,
  output logic                out_valid,
  output ttw_pkg::out_word_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW  = ttw_pkg::ADDR_W;
  localparam int CW  = ttw_pkg::CNT_W;
  localparam int CLW = ttw_pkg::COL_W;
  localparam int RW  = ttw_pkg::ROW_W;

  ttw_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic [ttw_pkg::CELL_W-1:0]   fill_cell_r, fill_cell_nxt;
  logic                         pending_r, pending_nxt;
  logic                         cp_valid_r, cp_valid_nxt;
  logic [AW-1:0]                cp_addr_r, cp_addr_nxt;
  logic                         rd_off_r, rd_off_nxt;
  logic [CLW-1:0]               col_r, col_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [7:0]                   color_r, color_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ttw_pkg::out_word_t           out_r, out_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ttw_pkg::CELL_W-1:0]   ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [ttw_pkg::CELL_W-1:0]   ram_rdata;

  logic                         accept;
  logic                         tgt_on_screen;
  logic [AW-1:0]                tgt_addr;
  logic                         cfg_we;

  logic [CLW-1:0]               pc_col0, pc_col1;
  logic [RW-1:0]                pc_row0, pc_row1;
  logic                         pc_we;
  logic [7:0]                   pc_glyph;
  logic [CLW-1:0]               pc_wcol;
  logic                         pc_scroll;

  logic                         emit;
  logic [7:0]                   emit_glyph, emit_attr;
  logic                         emit_off;

  ttw_ram #(
    .WIDTH(ttw_pkg::CELL_W),
    .DEPTH(ttw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != ttw_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && (paddr[2] == ttw_pkg::REG_TEXT_COLOR);
  assign prdata    = (paddr[2] == ttw_pkg::REG_TEXT_COLOR) ? {24'd0, color_r} : 32'd0;

  assign tgt_on_screen = (in_data.target_col < 8'(ttw_pkg::COLUMNS)) &&
                         (in_data.target_row < 8'(ttw_pkg::ROWS));
  assign tgt_addr = AW'(ttw_pkg::cell_addr(in_data.target_row, in_data.target_col));

  always_comb begin
    pc_col0  = col_r;
    pc_row0  = row_r;
    pc_we    = 1'b0;
    pc_glyph = in_data.glyph;
    pc_wcol  = col_r;
    unique case (in_data.glyph)
      ttw_pkg::CH_LF: begin
        pc_col0 = '0;
        pc_row0 = row_r + RW'(1);
      end
      ttw_pkg::CH_CR: begin
        pc_col0 = '0;
      end
      ttw_pkg::CH_TAB: begin
        pc_col0 = (col_r + CLW'(4)) & ~CLW'(3);
      end
      ttw_pkg::CH_BS: begin
        if (col_r != '0) begin
          pc_col0  = col_r - CLW'(1);
          pc_we    = 1'b1;
          pc_glyph = ttw_pkg::CH_SPACE;
          pc_wcol  = col_r - CLW'(1);
        end
      end
      default: begin
        pc_we   = 1'b1;
        pc_col0 = col_r + CLW'(1);
      end
    endcase
    pc_col1 = pc_col0;
    pc_row1 = pc_row0;
    if (pc_col0 >= CLW'(ttw_pkg::COLUMNS)) begin
      pc_col1 = '0;
      pc_row1 = pc_row0 + RW'(1);
    end
    pc_scroll = (pc_row1 >= RW'(ttw_pkg::ROWS));
    if (pc_scroll) begin
      pc_row1 = RW'(ttw_pkg::ROWS - 1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    fill_cell_nxt = fill_cell_r;
    pending_nxt   = pending_r;
    cp_valid_nxt  = 1'b0;
    cp_addr_nxt   = cp_addr_r;
    rd_off_nxt    = rd_off_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    color_nxt     = cfg_we ? pwdata[7:0] : color_r;
    ram_we        = 1'b0;
    ram_waddr     = tgt_addr;
    ram_wdata     = {in_data.attribute, in_data.glyph};
    ram_raddr     = tgt_addr;
    emit          = 1'b0;
    emit_glyph    = 8'd0;
    emit_attr     = 8'd0;
    emit_off      = 1'b0;

    unique case (state_r)
      ttw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data.command)
            ttw_pkg::CMD_PUT: begin
              ram_we    = pc_we;
              ram_waddr = AW'(ttw_pkg::cell_addr(8'(row_r), 8'(pc_wcol)));
              ram_wdata = {color_r, pc_glyph};
              col_nxt   = pc_col1;
              row_nxt   = pc_row1;
              if (pc_scroll) begin
                state_nxt = ttw_pkg::S_SCROLL;
                ptr_nxt   = CW'(ttw_pkg::COLUMNS);
              end else begin
                emit = 1'b1;
              end
            end
            ttw_pkg::CMD_CLEAR: begin
              state_nxt     = ttw_pkg::S_FILL;
              ptr_nxt       = '0;
              fill_cell_nxt = {color_r, ttw_pkg::CH_SPACE};
              pending_nxt   = 1'b1;
              col_nxt       = '0;
              row_nxt       = '0;
            end
            ttw_pkg::CMD_SET: begin
              col_nxt = (in_data.target_col < 8'(ttw_pkg::COLUMNS)) ?
                        CLW'(in_data.target_col) : CLW'(ttw_pkg::COLUMNS - 1);
              row_nxt = (in_data.target_row < 8'(ttw_pkg::ROWS)) ?
                        RW'(in_data.target_row) : RW'(ttw_pkg::ROWS - 1);
              emit    = 1'b1;
            end
            ttw_pkg::CMD_WRITE: begin
              ram_we   = tgt_on_screen;
              emit     = 1'b1;
              emit_off = !tgt_on_screen;
            end
            ttw_pkg::CMD_READ: begin
              state_nxt  = ttw_pkg::S_READ;
              rd_off_nxt = !tgt_on_screen;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ttw_pkg::S_READ: begin
        state_nxt  = ttw_pkg::S_IDLE;
        emit       = 1'b1;
        emit_off   = rd_off_r;
        emit_glyph = rd_off_r ? 8'd0 : ram_rdata[7:0];
        emit_attr  = rd_off_r ? 8'd0 : ram_rdata[15:8];
      end
      ttw_pkg::S_SCROLL: begin
        ram_raddr = ptr_r[AW-1:0];
        ram_we    = cp_valid_r;
        ram_waddr = cp_addr_r;
        ram_wdata = ram_rdata;
        if (ptr_r == CW'(ttw_pkg::CELLS)) begin
          state_nxt     = ttw_pkg::S_FILL;
          ptr_nxt       = CW'((ttw_pkg::ROWS - 1) * ttw_pkg::COLUMNS);
          fill_cell_nxt = {color_r, ttw_pkg::CH_SPACE};
          pending_nxt   = 1'b1;
        end else begin
          cp_valid_nxt = 1'b1;
          cp_addr_nxt  = AW'(ptr_r - CW'(ttw_pkg::COLUMNS));
          ptr_nxt      = ptr_r + CW'(1);
        end
      end
      ttw_pkg::S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = fill_cell_r;
        ptr_nxt   = ptr_r + CW'(1);
        if (ptr_r == CW'(ttw_pkg::CELLS - 1)) begin
          state_nxt   = ttw_pkg::S_IDLE;
          pending_nxt = 1'b0;
          emit        = pending_r;
        end
      end
      default: begin
        state_nxt = ttw_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt          = emit;
    out_nxt                = out_r;
    out_nxt.cur_col        = 7'(col_nxt);
    out_nxt.cur_row        = 5'(row_nxt);
    out_nxt.cursor_index   = 11'(ttw_pkg::cell_addr(8'(row_nxt), 8'(col_nxt)));
    out_nxt.read_glyph     = emit_glyph;
    out_nxt.read_attribute = emit_attr;
    out_nxt.off_screen     = emit_off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttw_pkg::S_FILL;
      ptr_r       <= '0;
      fill_cell_r <= {ttw_pkg::RESET_COLOR, ttw_pkg::CH_SPACE};
      pending_r   <= 1'b0;
      cp_valid_r  <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      color_r     <= ttw_pkg::RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_cell_r <= fill_cell_nxt;
      pending_r   <= pending_nxt;
      cp_valid_r  <= cp_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cp_addr_nxt;
    rd_off_r  <= rd_off_nxt;
    out_r     <= out_nxt;
  end

endmodule
